>>> design/bfcbc_pkg.sv
// shared types and constants for the blowfish-style cbc codec
`timescale 1ns / 1ps
package bfcbc_pkg;
  localparam int P_WORDS = 18;
  localparam int S_WORDS = 1024;
  localparam int TABLE_WORDS = P_WORDS + S_WORDS;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_ENC  = 2'd2,
    KIND_DEC  = 2'd3
  } kind_t;

  localparam logic RES_BLOCK = 1'b0;
  localparam logic RES_KEY   = 1'b1;
endpackage

>>> design/blowfish_variant_cbc_codec_top.sv
// top level of the blowfish-style cbc codec
`timescale 1ns / 1ps
// Blowfish-style 64-bit block cipher with CBC chaining. Load transactions write
// P and S words; key transactions collect bytes and the last byte runs the key
// expansion. An encrypt or decrypt transaction puts its result in the output
// register after a start state that sends the first half to the S boxes, then
// 16 rounds, in which the four S-box memories (one per box, synchronous read)
// are read at the half just updated; the whitening is folded into the last
// round. The next transaction is taken only once the result is gone. Key
// expansion first XORs the key into P (72 key-store reads through the
// registered read) and then runs 521 encryptions, each a start state, 16
// rounds and a state for the second table write, before its result comes.
// Load and non-final key transactions give no result and can follow back to
// back.
module blowfish_variant_cbc_codec_top
  import bfcbc_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 72
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [10:0] table_index,
  input  logic [31:0] table_word,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic [63:0] block_in,
  input  logic        first_block,
  input  logic [63:0] iv,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] block_out,
  output logic        result_kind
);
  localparam int KW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KA = $clog2(MAX_KEY_BYTES);
  localparam int KEY_READS = 4 * P_WORDS;

  typedef enum logic [2:0] {
    S_IDLE, S_PXOR, S_START, S_RND, S_WB
  } state_t;

  // memories
  logic [31:0] p_mem [P_WORDS];
  logic [31:0] s0 [256];
  logic [31:0] s1 [256];
  logic [31:0] s2 [256];
  logic [31:0] s3 [256];
  logic [7:0]  kmem [MAX_KEY_BYTES];

  state_t state;
  logic [KW-1:0] key_count;
  logic [KW-1:0] key_count_next;
  logic [63:0]   chain_value;
  logic [63:0]   prev_sel;
  logic [31:0]   l, r;     // l: half already xored with p, its s reads in flight
  logic [3:0]    rnd;      // round counter 0..15
  logic          dec;      // decrypting
  logic          expand;   // running key expansion
  logic [10:0]   wptr;     // expansion write index, 0..1040 step 2
  logic [4:0]    pidx;     // p xor index
  logic [KA-1:0] kidx;     // key byte read pointer
  logic [KW-1:0] kidx_inc;
  logic [KW-1:0] klen;
  logic [6:0]    nread;    // key bytes read so far in the p xor pass
  logic          kvalid;   // kq holds a requested byte
  logic [7:0]    kq;
  logic          k_we;
  logic [1:0]    bsel;     // byte of word being assembled
  logic [31:0]   kword;
  logic [63:0]   blk_saved;
  logic          res_load;

  // sync read ports of the s boxes
  logic [7:0]  ra, rb, rc, rd;
  logic [31:0] sa, sb, sc, sd;
  logic [31:0] f;
  logic [31:0] xin;   // half sent to the s boxes this cycle
  logic [63:0] res;   // cipher output in the last round

  // s box write port
  logic [3:0]  s_we;
  logic [7:0]  s_wa;
  logic [31:0] s_wd;
  logic [9:0]  lsidx, wsidx;

  // p indices: first round, next round and the final whitening pair
  logic [4:0] k0, kn, pfl, pfr;
  assign k0  = dec ? 5'd17 : 5'd0;
  assign kn  = dec ? 5'd16 - 5'(rnd) : 5'(rnd) + 5'd1;
  assign pfl = dec ? 5'd1 : 5'd16;
  assign pfr = dec ? 5'd0 : 5'd17;

  assign f = (sa + sb) ^ (sc + sd);
  assign ra = xin[31:24];
  assign rb = xin[23:16];
  assign rc = xin[15:8];
  assign rd = xin[7:0];

  always_comb begin
    xin = l ^ p_mem[k0];
    if (state == S_RND) xin = r ^ f ^ p_mem[kn];
  end

  // after 16 rounds the halves are swapped back and whitened
  assign res = {l ^ p_mem[pfr], r ^ f ^ p_mem[pfl]};

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign prev_sel = first_block ? iv : chain_value;
  assign key_count_next = (key_count < KW'(MAX_KEY_BYTES)) ? key_count + KW'(1) : key_count;
  assign kidx_inc = KW'(kidx) + KW'(1);
  assign k_we = in_valid && in_ready && (kind_t'(kind) == KIND_KEY)
                && (key_count < KW'(MAX_KEY_BYTES));
  assign lsidx = 10'(table_index - 11'(P_WORDS));
  assign wsidx = 10'(wptr - 11'(P_WORDS));

  // a result is loaded at the end of a block or of the whole expansion
  assign res_load = (state == S_RND && rnd == 4'd15 && !expand)
                    || (state == S_WB && wptr == 11'(TABLE_WORDS - 2));

  always_comb begin
    s_we = '0;
    s_wa = '0;
    s_wd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready && kind_t'(kind) == KIND_LOAD
            && table_index >= 11'(P_WORDS) && table_index < 11'(TABLE_WORDS)) begin
          s_we[lsidx[9:8]] = 1'b1;
          s_wa = lsidx[7:0];
          s_wd = table_word;
        end
      end
      S_RND: begin
        if (expand && rnd == 4'd15 && wptr >= 11'(P_WORDS)) begin
          s_we[wsidx[9:8]] = 1'b1;
          s_wa = wsidx[7:0];
          s_wd = res[63:32];
        end
      end
      S_WB: begin
        if (wptr >= 11'(P_WORDS)) begin
          s_we[wsidx[9:8]] = 1'b1;
          s_wa = {wsidx[7:1], 1'b1};
          s_wd = r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we[0]) s0[s_wa] <= s_wd;
    if (s_we[1]) s1[s_wa] <= s_wd;
    if (s_we[2]) s2[s_wa] <= s_wd;
    if (s_we[3]) s3[s_wa] <= s_wd;
    sa <= s0[ra];
    sb <= s1[rb];
    sc <= s2[rc];
    sd <= s3[rd];
  end

  // key store, one write and one registered read
  always_ff @(posedge clk) begin
    if (k_we) kmem[key_count[KA-1:0]] <= key_byte;
    kq <= kmem[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key_count <= '0;
      chain_value <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            unique case (kind_t'(kind))
              KIND_LOAD: begin
                if (table_index < 11'(P_WORDS)) p_mem[table_index[4:0]] <= table_word;
              end
              KIND_KEY: begin
                if (key_last) begin
                  key_count <= '0;
                  klen <= key_count_next;
                  pidx <= '0;
                  kidx <= '0;
                  nread <= '0;
                  kvalid <= 1'b0;
                  bsel <= '0;
                  kword <= '0;
                  expand <= 1'b1;
                  dec <= 1'b0;
                  state <= S_PXOR;
                end else key_count <= key_count_next;
              end
              default: begin
                dec <= (kind_t'(kind) == KIND_DEC);
                expand <= 1'b0;
                blk_saved <= block_in;
                if (kind_t'(kind) == KIND_ENC) begin
                  l <= block_in[63:32] ^ prev_sel[63:32];
                  r <= block_in[31:0] ^ prev_sel[31:0];
                end else begin
                  l <= block_in[63:32];
                  r <= block_in[31:0];
                end
                chain_value <= prev_sel;   // holds prev until finish
                state <= S_START;
              end
            endcase
          end
        end
        S_PXOR: begin
          // one key byte per cycle, cyclic over klen, through the registered key store read
          if (nread != 7'(KEY_READS)) begin
            kidx <= (kidx_inc == klen) ? '0 : KA'(kidx_inc);
            nread <= nread + 7'd1;
          end
          kvalid <= (nread != 7'(KEY_READS));
          if (kvalid) begin
            kword <= {kword[23:0], kq};
            bsel <= bsel + 2'd1;
            if (bsel == 2'd3) begin
              p_mem[pidx] <= p_mem[pidx] ^ {kword[23:0], kq};
              pidx <= pidx + 5'd1;
              if (pidx == 5'(P_WORDS - 1)) begin
                l <= '0;
                r <= '0;
                wptr <= '0;
                state <= S_START;
              end
            end
          end
        end
        S_START: begin
          // first half xored with its p word goes to the s boxes
          l <= xin;
          rnd <= '0;
          state <= S_RND;
        end
        S_RND: begin
          if (rnd != 4'd15) begin
            // f(l) is ready: r ^ f ^ p[next] becomes the new l
            l <= xin;
            r <= l;
            rnd <= rnd + 4'd1;
          end else if (expand) begin
            l <= res[63:32];
            r <= res[31:0];
            if (wptr < 11'(P_WORDS)) p_mem[wptr[4:0]] <= res[63:32];
            state <= S_WB;
          end else begin
            result_kind <= RES_BLOCK;
            if (dec) begin
              block_out <= res ^ chain_value;
              chain_value <= blk_saved;
            end else begin
              block_out <= res;
              chain_value <= res;
            end
            state <= S_IDLE;
          end
        end
        S_WB: begin
          // second word of the pair, then the next encryption or, after the last pair, the key result
          if (wptr < 11'(P_WORDS)) p_mem[5'(wptr + 11'd1)] <= r;
          wptr <= wptr + 11'd2;
          if (wptr == 11'(TABLE_WORDS - 2)) begin
            block_out <= '0;
            result_kind <= RES_KEY;
            state <= S_IDLE;
          end else state <= S_START;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register is not overwritten while it waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_out))
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accepting while result waits");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE)
    else $error("result waiting while busy");
  assert property (@(posedge clk) disable iff (rst)
    state == S_PXOR |-> pidx < 5'(P_WORDS))
    else $error("p xor index overflow");
endmodule
